/* rtl/hcmh_pkg.sv */
package hcmh_pkg;

    localparam int WEIGHT_W = 16;
    localparam int COST_W   = 48;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS,
        S_PUSH_CHK,
        S_PUSH_CMP,
        S_MERGE_CHK,
        S_POP_RD0,
        S_POP_RDLAST,
        S_POP_TAKE,
        S_POP_CHK,
        S_POP_LEFT,
        S_POP_RIGHT,
        S_POP_CMP,
        S_POP_END,
        S_SUM_ACC,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_INS,
        CMD_PUSH_CHK,
        CMD_PUSH_CMP,
        CMD_POP_RD0,
        CMD_POP_RDLAST,
        CMD_POP_TAKE,
        CMD_POP_CHK,
        CMD_POP_LEFT,
        CMD_POP_RIGHT,
        CMD_POP_CMP,
        CMD_POP_END_A,
        CMD_POP_END_B,
        CMD_SUM_ACC,
        CMD_EMIT
    } t_cmd;

    typedef struct packed {
        logic room;
        logic last;
        logic len_gt1;
        logic pos_gt1;
        logic v_lt_rd;
        logic kid_gt_len;
        logic right_exists;
        logic v_lt_c;
    } t_status;

endpackage

/* rtl/hcmh_ctrl.sv */
module hcmh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  hcmh_pkg::t_status i_status,
    output hcmh_pkg::t_cmd  o_cmd,
    output logic            busy
);

    hcmh_pkg::t_state r_state, n_state;
    logic             r_pop_b, n_pop_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcmh_pkg::S_IDLE;
            r_pop_b <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pop_b <= n_pop_b;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pop_b = r_pop_b;
        case (r_state)
            hcmh_pkg::S_IDLE: begin
                if (start) n_state = hcmh_pkg::S_INS;
            end
            hcmh_pkg::S_INS: begin
                if (i_status.room)      n_state = hcmh_pkg::S_PUSH_CHK;
                else if (i_status.last) n_state = hcmh_pkg::S_MERGE_CHK;
                else                    n_state = hcmh_pkg::S_IDLE;
            end
            hcmh_pkg::S_PUSH_CHK: begin
                if (i_status.pos_gt1)   n_state = hcmh_pkg::S_PUSH_CMP;
                else if (i_status.last) n_state = hcmh_pkg::S_MERGE_CHK;
                else                    n_state = hcmh_pkg::S_IDLE;
            end
            hcmh_pkg::S_PUSH_CMP: begin
                if (i_status.v_lt_rd)   n_state = hcmh_pkg::S_PUSH_CHK;
                else if (i_status.last) n_state = hcmh_pkg::S_MERGE_CHK;
                else                    n_state = hcmh_pkg::S_IDLE;
            end
            hcmh_pkg::S_MERGE_CHK: begin
                if (i_status.len_gt1) n_state = hcmh_pkg::S_POP_RD0;
                else                  n_state = hcmh_pkg::S_EMIT;
            end
            hcmh_pkg::S_POP_RD0:    n_state = hcmh_pkg::S_POP_RDLAST;
            hcmh_pkg::S_POP_RDLAST: n_state = hcmh_pkg::S_POP_TAKE;
            hcmh_pkg::S_POP_TAKE:   n_state = hcmh_pkg::S_POP_CHK;
            hcmh_pkg::S_POP_CHK: begin
                if (i_status.kid_gt_len) n_state = hcmh_pkg::S_POP_END;
                else                     n_state = hcmh_pkg::S_POP_LEFT;
            end
            hcmh_pkg::S_POP_LEFT: begin
                if (i_status.right_exists) n_state = hcmh_pkg::S_POP_RIGHT;
                else                       n_state = hcmh_pkg::S_POP_CMP;
            end
            hcmh_pkg::S_POP_RIGHT: n_state = hcmh_pkg::S_POP_CMP;
            hcmh_pkg::S_POP_CMP: begin
                if (i_status.v_lt_c) n_state = hcmh_pkg::S_POP_END;
                else                 n_state = hcmh_pkg::S_POP_CHK;
            end
            hcmh_pkg::S_POP_END: begin
                // second pop of the pair goes on to the sum
                if (r_pop_b) begin
                    n_state = hcmh_pkg::S_SUM_ACC;
                    n_pop_b = 1'b0;
                end else begin
                    n_state = hcmh_pkg::S_POP_RD0;
                    n_pop_b = 1'b1;
                end
            end
            hcmh_pkg::S_SUM_ACC: n_state = hcmh_pkg::S_PUSH_CHK;
            hcmh_pkg::S_EMIT:    n_state = hcmh_pkg::S_IDLE;
            default:             n_state = hcmh_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = hcmh_pkg::CMD_NONE;
        busy  = 1'b1;
        case (r_state)
            hcmh_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) o_cmd = hcmh_pkg::CMD_LOAD;
            end
            hcmh_pkg::S_INS:        o_cmd = hcmh_pkg::CMD_INS;
            hcmh_pkg::S_PUSH_CHK:   o_cmd = hcmh_pkg::CMD_PUSH_CHK;
            hcmh_pkg::S_PUSH_CMP:   o_cmd = hcmh_pkg::CMD_PUSH_CMP;
            hcmh_pkg::S_MERGE_CHK:  o_cmd = hcmh_pkg::CMD_NONE;
            hcmh_pkg::S_POP_RD0:    o_cmd = hcmh_pkg::CMD_POP_RD0;
            hcmh_pkg::S_POP_RDLAST: o_cmd = hcmh_pkg::CMD_POP_RDLAST;
            hcmh_pkg::S_POP_TAKE:   o_cmd = hcmh_pkg::CMD_POP_TAKE;
            hcmh_pkg::S_POP_CHK:    o_cmd = hcmh_pkg::CMD_POP_CHK;
            hcmh_pkg::S_POP_LEFT:   o_cmd = hcmh_pkg::CMD_POP_LEFT;
            hcmh_pkg::S_POP_RIGHT:  o_cmd = hcmh_pkg::CMD_POP_RIGHT;
            hcmh_pkg::S_POP_CMP:    o_cmd = hcmh_pkg::CMD_POP_CMP;
            hcmh_pkg::S_POP_END: begin
                if (r_pop_b) o_cmd = hcmh_pkg::CMD_POP_END_B;
                else         o_cmd = hcmh_pkg::CMD_POP_END_A;
            end
            hcmh_pkg::S_SUM_ACC: o_cmd = hcmh_pkg::CMD_SUM_ACC;
            hcmh_pkg::S_EMIT:    o_cmd = hcmh_pkg::CMD_EMIT;
            default:             o_cmd = hcmh_pkg::CMD_NONE;
        endcase
    end

endmodule

/* rtl/hcmh_dp.sv */
module hcmh_dp #(
    parameter int CAPACITY = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hcmh_pkg::t_cmd                    i_cmd,
    input  logic [hcmh_pkg::WEIGHT_W-1:0]     i_weight,
    input  logic                              i_last_weight,
    output hcmh_pkg::t_status                 o_status,
    output logic [hcmh_pkg::COST_W-1:0]       o_total_cost,
    output logic                              o_overflow,
    output logic                              o_valid
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int KW = LW + 1;
    localparam int CW = hcmh_pkg::COST_W;

    logic [CW-1:0] mem [CAPACITY];

    logic [LW-1:0] r_len, r_pos;
    logic [KW-1:0] r_kid;
    logic [CW-1:0] r_v, r_c, r_top, r_a, r_acc, r_rdata, r_out_total;
    logic          r_ovf, r_last, r_out_ovf, r_out_valid;

    logic [LW-1:0] pos_m1, par_m1, len_m1, len_p1;
    logic [KW-1:0] kid2, kid2_m1;
    logic          v_lt_rd, v_lt_c;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [CW-1:0] wr_data;

    assign pos_m1  = r_pos - LW'(1);
    assign par_m1  = (r_pos >> 1) - LW'(1);
    assign len_m1  = r_len - LW'(1);
    assign len_p1  = r_len + LW'(1);
    assign kid2    = {r_pos, 1'b0};
    assign kid2_m1 = kid2 - KW'(1);
    assign v_lt_rd = r_v < r_rdata;
    assign v_lt_c  = r_v < r_c;

    assign o_status.room         = r_len != LW'(CAPACITY);
    assign o_status.last         = r_last;
    assign o_status.len_gt1      = r_len > LW'(1);
    assign o_status.pos_gt1      = r_pos > LW'(1);
    assign o_status.v_lt_rd      = v_lt_rd;
    assign o_status.kid_gt_len   = kid2 > {1'b0, r_len};
    assign o_status.right_exists = r_kid < {1'b0, r_len};
    assign o_status.v_lt_c       = v_lt_c;

    // memory port selection
    always_comb begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = pos_m1[AW-1:0];
        wr_data = r_v;
        case (i_cmd)
            hcmh_pkg::CMD_PUSH_CHK: begin
                rd_addr = par_m1[AW-1:0];
                wr_en   = !o_status.pos_gt1;
            end
            hcmh_pkg::CMD_PUSH_CMP: begin
                wr_en   = 1'b1;
                wr_data = v_lt_rd ? r_rdata : r_v;
            end
            hcmh_pkg::CMD_POP_RDLAST: rd_addr = len_m1[AW-1:0];
            hcmh_pkg::CMD_POP_CHK:    rd_addr = kid2_m1[AW-1:0];
            hcmh_pkg::CMD_POP_LEFT:   rd_addr = r_kid[AW-1:0];
            hcmh_pkg::CMD_POP_CMP: begin
                wr_en   = !v_lt_c;
                wr_data = r_c;
            end
            hcmh_pkg::CMD_POP_END_A,
            hcmh_pkg::CMD_POP_END_B: wr_en = r_len != '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (i_cmd)
                hcmh_pkg::CMD_LOAD: r_last <= i_last_weight;
                hcmh_pkg::CMD_INS: begin
                    // drop the weight when full
                    if (o_status.room) r_len <= len_p1;
                    else               r_ovf <= 1'b1;
                end
                hcmh_pkg::CMD_POP_TAKE: r_len <= len_m1;
                hcmh_pkg::CMD_SUM_ACC: begin
                    r_acc <= r_acc + r_v;
                    r_len <= len_p1;
                end
                hcmh_pkg::CMD_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_len       <= '0;
                    r_acc       <= '0;
                    r_ovf       <= 1'b0;
                    r_last      <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            hcmh_pkg::CMD_LOAD:
                r_v <= {{(CW - hcmh_pkg::WEIGHT_W){1'b0}}, i_weight};
            hcmh_pkg::CMD_INS:      r_pos <= len_p1;
            hcmh_pkg::CMD_PUSH_CMP: if (v_lt_rd) r_pos <= r_pos >> 1;
            hcmh_pkg::CMD_POP_RDLAST: r_top <= r_rdata;
            hcmh_pkg::CMD_POP_TAKE: begin
                r_v   <= r_rdata;
                r_pos <= LW'(1);
            end
            hcmh_pkg::CMD_POP_CHK:  r_kid <= kid2;
            hcmh_pkg::CMD_POP_LEFT: r_c <= r_rdata;
            hcmh_pkg::CMD_POP_RIGHT: begin
                // right child wins only when strictly smaller
                if (r_rdata < r_c) begin
                    r_c   <= r_rdata;
                    r_kid <= r_kid + KW'(1);
                end
            end
            hcmh_pkg::CMD_POP_CMP:   if (!v_lt_c) r_pos <= r_kid[LW-1:0];
            hcmh_pkg::CMD_POP_END_A: r_a <= r_top;
            hcmh_pkg::CMD_POP_END_B: r_v <= r_a + r_top;
            hcmh_pkg::CMD_SUM_ACC:   r_pos <= len_p1;
            hcmh_pkg::CMD_EMIT: begin
                r_out_total <= r_acc;
                r_out_ovf   <= r_ovf;
            end
            default: ;
        endcase
    end

    assign o_total_cost = r_out_total;
    assign o_overflow   = r_out_ovf;
    assign o_valid      = r_out_valid;

endmodule

/* rtl/huffman_cost_min_heap.sv */
// Channel   | Signals                          | Transfer
// ----------+----------------------------------+---------------------------------
// weight in | start, busy, i_weight,           | edge with start high, busy low
//           | i_last_weight                    |
// result    | o_valid, o_total_cost,           | o_valid high for one cycle
//           | o_overflow                       |
//
// An insert keeps busy high through an insert state, then a check and a compare
// state per level the weight rises, and a last check at the root or a compare
// where it stops; each level needs one heap memory read. A last weight adds the
// merge: a pop reads the root and the last entry, takes the last as the value
// to sift down, then per level reads the left and any right child and compares;
// a pair is a check, two pops, a sum and a push; a final check and report end it.
// Reset (i_rst_n low, synchronous) empties the heap and clears the running total.
// The result strobe cannot be stalled; busy holds off new weights.
module huffman_cost_min_heap #(
    parameter int CAPACITY = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [hcmh_pkg::WEIGHT_W-1:0] i_weight,
    input  logic                          i_last_weight,
    output logic                          o_valid,
    output logic [hcmh_pkg::COST_W-1:0]   o_total_cost,
    output logic                          o_overflow
);

    hcmh_pkg::t_cmd    cmd;
    hcmh_pkg::t_status status;

    hcmh_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    hcmh_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_weight      (i_weight),
        .i_last_weight (i_last_weight),
        .o_status      (status),
        .o_total_cost  (o_total_cost),
        .o_overflow    (o_overflow),
        .o_valid       (o_valid)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after weight transfer");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without preceding work");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule
